// ===== src/intel_hex_record_encoder_defines.svh =====
// Assertion macros shared by the Intel HEX encoder sources.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef INTEL_HEX_RECORD_ENCODER_DEFINES_SVH
`define INTEL_HEX_RECORD_ENCODER_DEFINES_SVH

// Implication checked at every rising edge outside reset.
`define IHEX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define IHEX_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/ihex_pkg.sv =====
// Shared types, sequencer constants and helper functions for the Intel HEX encoder.
// Depends on nothing.
package ihex_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } in_word_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_of_run;
    } out_word_t;

    localparam int STEP_W = 5;

    // Program layout: data record from step 0, end record from END_STEP.
    localparam logic [STEP_W-1:0] LOOP_STEP = 5'd9;
    localparam logic [STEP_W-1:0] END_STEP  = 5'd14;

    typedef enum logic [1:0] {
        UK_CHAR,
        UK_HI,
        UK_LO
    } ukind_t;

    typedef enum logic [2:0] {
        US_COUNT,
        US_ADDR_HI,
        US_ADDR_LO,
        US_ZERO,
        US_BUF,
        US_CHK
    } usrc_t;

    typedef struct packed {
        ukind_t     kind;
        usrc_t      src;
        logic [7:0] chr;
        logic       acc;
        logic       loop;
        logic       rec_end;
        logic       fin;
    } uword_t;

    function automatic uword_t mk_char(input logic [7:0] c);
        uword_t w;
        w = '0;
        w.kind = UK_CHAR;
        w.src  = US_ZERO;
        w.chr  = c;
        return w;
    endfunction

    function automatic uword_t mk_hex(input ukind_t k, input usrc_t s, input logic acc);
        uword_t w;
        w = '0;
        w.kind = k;
        w.src  = s;
        w.acc  = acc;
        return w;
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

// ===== src/ihex_ucode_rom.sv =====
// Control store of the encoder sequencer: one control word per program step.
// Depends on ihex_pkg.
module ihex_ucode_rom (
    input  logic [ihex_pkg::STEP_W-1:0] step,
    output ihex_pkg::uword_t            word
);

    always_comb
    begin
        case (step)
            5'd0:  word = ihex_pkg::mk_char(8'h3A);
            5'd1:  word = ihex_pkg::mk_hex(ihex_pkg::UK_HI, ihex_pkg::US_COUNT, 1'b0);
            5'd2:  word = ihex_pkg::mk_hex(ihex_pkg::UK_LO, ihex_pkg::US_COUNT, 1'b1);
            5'd3:  word = ihex_pkg::mk_hex(ihex_pkg::UK_HI, ihex_pkg::US_ADDR_HI, 1'b0);
            5'd4:  word = ihex_pkg::mk_hex(ihex_pkg::UK_LO, ihex_pkg::US_ADDR_HI, 1'b1);
            5'd5:  word = ihex_pkg::mk_hex(ihex_pkg::UK_HI, ihex_pkg::US_ADDR_LO, 1'b0);
            5'd6:  word = ihex_pkg::mk_hex(ihex_pkg::UK_LO, ihex_pkg::US_ADDR_LO, 1'b1);
            5'd7:  word = ihex_pkg::mk_hex(ihex_pkg::UK_HI, ihex_pkg::US_ZERO, 1'b0);
            5'd8:  word = ihex_pkg::mk_hex(ihex_pkg::UK_LO, ihex_pkg::US_ZERO, 1'b0);
            5'd9:  word = ihex_pkg::mk_hex(ihex_pkg::UK_HI, ihex_pkg::US_BUF, 1'b0);
            5'd10:
            begin
                word = ihex_pkg::mk_hex(ihex_pkg::UK_LO, ihex_pkg::US_BUF, 1'b1);
                word.loop = 1'b1;
            end
            5'd11: word = ihex_pkg::mk_hex(ihex_pkg::UK_HI, ihex_pkg::US_CHK, 1'b0);
            5'd12: word = ihex_pkg::mk_hex(ihex_pkg::UK_LO, ihex_pkg::US_CHK, 1'b0);
            5'd13:
            begin
                word = ihex_pkg::mk_char(8'h0A);
                word.rec_end = 1'b1;
            end
            // End record ":00000001FF" followed by a newline.
            5'd14: word = ihex_pkg::mk_char(8'h3A);
            5'd15: word = ihex_pkg::mk_char(8'h30);
            5'd16: word = ihex_pkg::mk_char(8'h30);
            5'd17: word = ihex_pkg::mk_char(8'h30);
            5'd18: word = ihex_pkg::mk_char(8'h30);
            5'd19: word = ihex_pkg::mk_char(8'h30);
            5'd20: word = ihex_pkg::mk_char(8'h30);
            5'd21: word = ihex_pkg::mk_char(8'h30);
            5'd22: word = ihex_pkg::mk_char(8'h31);
            5'd23: word = ihex_pkg::mk_char(8'h46);
            5'd24: word = ihex_pkg::mk_char(8'h46);
            5'd25:
            begin
                word = ihex_pkg::mk_char(8'h0A);
                word.fin = 1'b1;
            end
            default:
            begin
                word = ihex_pkg::mk_char(8'h0A);
                word.fin = 1'b1;
            end
        endcase
    end

endmodule

// ===== src/intel_hex_record_encoder.sv =====
// A completing word sets busy and step; the first character is then registered for output.
// Throughput: one character per cycle while out_stall is low; a record of n bytes is
// 12 + 2n characters, the end record 12 more, and the input stalls while the sequencer
// walks its program. A byte that does not complete a record is taken with no output.
// Reset clears fill count, load address and sequencer; the limit returns to 16.
// The record buffer is not cleared. Depends on ihex_pkg, ihex_ucode_rom and the defines header.
`include "intel_hex_record_encoder_defines.svh"

module intel_hex_record_encoder #(
    parameter int MAX_RECORD_BYTES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ihex_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ihex_pkg::out_word_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [4:0]          cfg_data
);

    localparam int CW   = $clog2(MAX_RECORD_BYTES + 1);
    localparam int IDXW = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
    localparam logic [CW-1:0] MAX_FILL = CW'(MAX_RECORD_BYTES);

    logic [7:0]    buf_mem [MAX_RECORD_BYTES];
    logic [7:0]    buf_rd_reg;

    logic [4:0]    limit_reg, limit_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [15:0]   addr_reg, addr_next;
    logic          busy_reg, busy_next;
    logic          endf_reg, endf_next;
    logic [ihex_pkg::STEP_W-1:0] step_reg, step_next;
    logic [IDXW-1:0] idx_reg, idx_next;
    logic [7:0]    sum_reg, sum_next;
    logic          ovld_reg, ovld_next;
    ihex_pkg::out_word_t oword_reg, oword_next;

    ihex_pkg::uword_t uw;
    logic          in_acc;
    logic          adv;
    logic          room;
    logic [CW-1:0] fill_ins;
    logic [4:0]    lim;
    logic [7:0]    sel_byte;
    logic [3:0]    nib;
    logic [7:0]    chr;
    logic [CW-1:0] idx_inc;

    ihex_ucode_rom u_rom (
        .step (step_reg),
        .word (uw)
    );

    assign in_stall  = busy_reg;
    assign cfg_ready = !busy_reg;
    assign out_valid = ovld_reg;
    assign out_data  = oword_reg;

    assign in_acc   = in_valid && !busy_reg;
    assign adv      = busy_reg && (!ovld_reg || !out_stall);
    assign room     = fill_reg < MAX_FILL;
    assign fill_ins = room ? fill_reg + CW'(1) : fill_reg;
    assign idx_inc  = CW'(idx_reg) + CW'(1);

    always_comb
    begin
        if (limit_reg == 5'd0) begin
            lim = 5'd1;
        end else if (limit_reg > 5'(MAX_RECORD_BYTES)) begin
            lim = 5'(MAX_RECORD_BYTES);
        end else begin
            lim = limit_reg;
        end
    end

    always_comb
    begin
        case (uw.src)
            ihex_pkg::US_COUNT:   sel_byte = 8'(fill_reg);
            ihex_pkg::US_ADDR_HI: sel_byte = addr_reg[15:8];
            ihex_pkg::US_ADDR_LO: sel_byte = addr_reg[7:0];
            ihex_pkg::US_BUF:     sel_byte = buf_rd_reg;
            ihex_pkg::US_CHK:     sel_byte = 8'd0 - sum_reg;
            default:              sel_byte = 8'd0;
        endcase
        nib = (uw.kind == ihex_pkg::UK_HI) ? sel_byte[7:4] : sel_byte[3:0];
        chr = (uw.kind == ihex_pkg::UK_CHAR) ? uw.chr : ihex_pkg::hex_ascii(nib);
    end

    always_comb
    begin
        limit_next = limit_reg;
        fill_next  = fill_reg;
        addr_next  = addr_reg;
        busy_next  = busy_reg;
        endf_next  = endf_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        ovld_next  = ovld_reg;
        oword_next = oword_reg;

        if (cfg_valid && cfg_ready) begin
            limit_next = cfg_data;
        end

        if (ovld_reg && !out_stall) begin
            ovld_next = 1'b0;
        end

        if (in_acc) begin
            idx_next = '0;
            sum_next = 8'd0;
            if (in_data.end_of_data) begin
                busy_next = 1'b1;
                endf_next = 1'b1;
                step_next = (fill_reg == '0) ? ihex_pkg::END_STEP : '0;
            end else begin
                fill_next = fill_ins;
                if (5'(fill_ins) >= lim) begin
                    busy_next = 1'b1;
                    endf_next = 1'b0;
                    step_next = '0;
                end
            end
        end

        if (adv) begin
            ovld_next = 1'b1;
            oword_next.text_char   = chr;
            oword_next.last_of_run = 1'b0;
            step_next = step_reg + 1'b1;
            if (uw.acc) begin
                sum_next = sum_reg + sel_byte;
            end
            if (uw.loop) begin
                idx_next = idx_reg + 1'b1;
                if (idx_inc != fill_reg) begin
                    step_next = ihex_pkg::LOOP_STEP;
                end
            end
            if (uw.rec_end) begin
                addr_next = addr_reg + 16'(fill_reg);
                fill_next = '0;
                if (!endf_reg) begin
                    busy_next = 1'b0;
                    oword_next.last_of_run = 1'b1;
                end
            end
            if (uw.fin) begin
                busy_next = 1'b0;
                endf_next = 1'b0;
                fill_next = '0;
                addr_next = 16'd0;
                oword_next.last_of_run = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            limit_reg <= 5'd16;
            fill_reg  <= '0;
            addr_reg  <= 16'd0;
            busy_reg  <= 1'b0;
            endf_reg  <= 1'b0;
            step_reg  <= '0;
            idx_reg   <= '0;
            sum_reg   <= 8'd0;
            ovld_reg  <= 1'b0;
        end else begin
            limit_reg <= limit_next;
            fill_reg  <= fill_next;
            addr_reg  <= addr_next;
            busy_reg  <= busy_next;
            endf_reg  <= endf_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oword_reg <= oword_next;
    end

    // The buffer only ever takes a byte at the current fill position.
    // The read port follows the next loop index, so the byte is ready when its step runs.
    always_ff @(posedge clk)
    begin
        if (in_acc && !in_data.end_of_data && room) begin
            buf_mem[fill_reg[IDXW-1:0]] <= in_data.data_byte;
        end
        buf_rd_reg <= buf_mem[idx_next];
    end

    `IHEX_NEVER(a_fill_bound, fill_reg > MAX_FILL, "fill count beyond buffer depth")
    `IHEX_ASSERT(a_rec_nonempty, (busy_reg && !endf_reg) |-> (fill_reg != '0),
        "data record started with an empty buffer")
    `IHEX_ASSERT(a_last_idle, (adv && (uw.fin || (uw.rec_end && !endf_reg))) |=>
        (!busy_reg && out_valid && out_data.last_of_run), "final character did not end the run")
    `IHEX_NEVER(a_loop_index, busy_reg && uw.loop && (idx_inc > fill_reg),
        "data loop ran past the buffered bytes")

endmodule

// ===== tb/sv/intel_hex_record_encoder_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the Intel HEX record encoder: a stimulus queue feeds a
// stalling driver, and a monitor checks every output character against a built-in encoder.
// Depends on ihex_pkg and the intel_hex_record_encoder RTL.
module intel_hex_record_encoder_tb;

    localparam int MAX_BYTES   = 16;
    localparam int IDLE_TAIL   = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 4000000;
    localparam string END_TEXT = ":00000001FF";
    localparam logic [7:0] NEWLINE = 8'h0A;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    ihex_pkg::in_word_t  in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    ihex_pkg::out_word_t out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [4:0]          cfg_data = '0;

    intel_hex_record_encoder #(.MAX_RECORD_BYTES(MAX_BYTES)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Stimulus and expectations.
    ihex_pkg::in_word_t  pending_words [$];
    ihex_pkg::out_word_t text_expected [$];

    // Shadow encoder state.
    logic [4:0]  limit_reg = 5'd16;
    logic [7:0]  rec_bytes [MAX_BYTES];
    logic [4:0]  rec_fill = '0;
    logic [15:0] rec_addr = '0;

    // Handshake flags sampled at the rising edge, used at the falling edge.
    bit in_taken  = 1'b0;
    bit out_taken = 1'b0;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int tx_gap = 0;
    int rx_wait = 0;
    int hold_reqs = 0;
    int hold_served = 0;
    int hold_left = 0;
    int errors = 0;
    int cycle_count = 0;
    ihex_pkg::out_word_t want_word;

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic int draw_wait(input bit on);
        if (!on) return 0;
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h41 + 8'(nib) - 8'd10;
    endfunction

    task automatic push_char(input logic [7:0] c);
        ihex_pkg::out_word_t t;
        t.text_char   = c;
        t.last_of_run = 1'b0;
        text_expected.insert(text_expected.size(), t);
    endtask

    task automatic push_hex(input logic [7:0] v);
        push_char(hex_char(v[7:4]));
        push_char(hex_char(v[3:0]));
    endtask

    task automatic emit_record();
        logic [7:0] sum;
        int i;
        sum = 8'(rec_fill) + rec_addr[15:8] + rec_addr[7:0];
        push_char(":");
        push_hex(8'(rec_fill));
        push_hex(rec_addr[15:8]);
        push_hex(rec_addr[7:0]);
        push_hex(8'h00);
        for (i = 0; i < int'(rec_fill); i++) begin
            push_hex(rec_bytes[i]);
            sum = sum + rec_bytes[i];
        end
        push_hex(8'h00 - sum);
        push_char(NEWLINE);
        rec_addr = rec_addr + 16'(rec_fill);
        rec_fill = '0;
    endtask

    // Works out every character that one accepted word causes.
    task automatic encode_word(input ihex_pkg::in_word_t w);
        int lim;
        int start;
        int i;
        ihex_pkg::out_word_t t;
        lim = int'(limit_reg);
        if (lim < 1) lim = 1;
        if (lim > MAX_BYTES) lim = MAX_BYTES;
        start = text_expected.size();
        if (w.end_of_data) begin
            if (rec_fill != 0) emit_record();
            for (i = 0; i < END_TEXT.len(); i++) push_char(END_TEXT[i]);
            push_char(NEWLINE);
            rec_fill = '0;
            rec_addr = '0;
        end else begin
            if (rec_fill < MAX_BYTES) begin
                rec_bytes[rec_fill[3:0]] = w.data_byte;
                rec_fill = rec_fill + 5'd1;
            end
            if (int'(rec_fill) >= lim) emit_record();
        end
        if (text_expected.size() > start) begin
            t = text_expected.pop_back();
            t.last_of_run = 1'b1;
            text_expected.insert(text_expected.size(), t);
        end
    endtask

    task automatic note_fault(input string what, input int want, input int got);
        errors++;
        $error("%s: expected %0h, got %0h", what, want, got);
    endtask

    // Monitor: checks output words, tracks register writes and predicts accepted words.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            in_taken  = 1'b0;
            out_taken = 1'b0;
            if (rst_n) begin
                if (out_valid && !out_stall) begin
                    out_taken = 1'b1;
                    if (text_expected.size() == 0) begin
                        note_fault("unexpected text_char", 0, out_data.text_char);
                    end else begin
                        want_word = text_expected.pop_front();
                        if (out_data.text_char !== want_word.text_char)
                            note_fault("text_char", want_word.text_char, out_data.text_char);
                        if (out_data.last_of_run !== want_word.last_of_run)
                            note_fault("last_of_run", want_word.last_of_run,
                                       out_data.last_of_run);
                    end
                end
                if (cfg_valid && cfg_ready) limit_reg = cfg_data;
                if (in_valid && !in_stall) begin
                    in_taken = 1'b1;
                    encode_word(in_data);
                end
            end
        end
    end

    // Driver: offers queued words with random gaps between them.
    always @(negedge clk) begin
        logic               next_valid;
        ihex_pkg::in_word_t next_data;
        if (rst_n) begin
            next_valid = in_valid;
            next_data  = in_data;
            if (in_valid && in_taken) begin
                next_valid = 1'b0;
                tx_gap = draw_wait(tx_idle_on);
            end
            if (!next_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_words.size() > 0) begin
                    next_data  = pending_words.pop_front();
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;
            in_data  <= next_data;
        end
    end

    // Receiver: random stalls per word, plus long hold-offs on request.
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_served != hold_reqs) begin
                hold_served = hold_reqs;
                hold_left   = HOLD_CYCLES;
            end
            if (out_taken) rx_wait = draw_wait(rx_idle_on);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        ihex_pkg::in_word_t w;
        w.data_byte   = b;
        w.end_of_data = 1'b0;
        pending_words.insert(pending_words.size(), w);
    endtask

    // The data byte of an end marker carries noise; the block must ignore it.
    task automatic queue_end();
        ihex_pkg::in_word_t w;
        w.data_byte   = 8'($urandom_range(0, 255));
        w.end_of_data = 1'b1;
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || in_valid) @(posedge clk);
        while (text_expected.size() != 0) @(posedge clk);
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    task automatic write_limit(input logic [4:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [4:0] fixed_limits [6];
        int ph;
        int k;
        int n;
        fixed_limits = '{5'd31, 5'd17, 5'd1, 5'd0, 5'd16, 5'd7};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset limit, partial flush, end marker on an empty buffer.
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h5A);
        queue_end();
        queue_end();
        wait_idle();
        write_limit(5'd1);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_end();
        wait_idle();
        // A limit of zero behaves as one.
        write_limit(5'd0);
        queue_byte(8'h3C);
        queue_byte(8'hC3);
        wait_idle();
        // Lowering the limit below the fill: the next byte closes a record of all four.
        write_limit(5'd4);
        queue_byte(8'h11);
        queue_byte(8'h22);
        queue_byte(8'h33);
        wait_idle();
        write_limit(5'd1);
        queue_byte(8'h44);
        queue_end();
        wait_idle();

        // Random phases over a spread of limits, the extremes first.
        for (ph = 0; ph < 9; ph++) begin
            wait_idle();
            if (ph < 6) write_limit(fixed_limits[ph]);
            else write_limit(5'($urandom_range(0, 31)));
            tx_idle_on = (ph % 4) != 3;
            rx_idle_on = (ph % 3) != 2;
            n = $urandom_range(22, 36);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 24) == 0) queue_end();
                else queue_byte(8'($urandom_range(0, 255)));
            end
        end

        // Pressure: the receiver holds off while the sender keeps offering.
        wait_idle();
        write_limit(5'd16);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_reqs++;
        for (k = 0; k < 60; k++) queue_byte(8'($urandom_range(0, 255)));
        queue_end();

        // An unaligned record size with idling back on, closed by an end marker.
        wait_idle();
        write_limit(5'd7);
        rx_idle_on = 1'b1;
        tx_idle_on = 1'b1;
        for (k = 0; k < 24; k++) queue_byte(8'($urandom_range(0, 255)));
        queue_end();
        wait_idle();

        if (errors == 0 && text_expected.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
